FILE: rtl/core/gdad_pkg.sv
// Package for the Gregorian date advance unit: item structs, controller
// command/status structs, calendar constants and month length helpers.
// No dependencies.
package gdad_pkg;

   // Field widths fixed by the item format
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int OFFSET_W = 16;
   // Days still reachable: offset plus up to one month
   localparam int REACH_W  = OFFSET_W + 1;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] LEN_31    = 5'd31;
   localparam logic [DAY_W-1:0] LEN_30    = 5'd30;
   localparam logic [DAY_W-1:0] LEN_29    = 5'd29;
   localparam logic [DAY_W-1:0] LEN_28    = 5'd28;

   // Reciprocal of 25 scaled by 2^17; exact floor for all 14-bit years
   localparam int                RECIP_SHIFT = 17;
   localparam logic [12:0]       RECIP_25    = 13'd5243;
   localparam int                PROD_W      = YEAR_W + 13;
   localparam int                QUOT_W      = PROD_W - RECIP_SHIFT;

   typedef struct packed {
      logic [DAY_W-1:0]    start_day;
      logic [MONTH_W-1:0]  start_month;
      logic [YEAR_W-1:0]   start_year;
      logic [OFFSET_W-1:0] day_offset;
   } gdad_req_type;

   typedef struct packed {
      logic [DAY_W-1:0]   result_day;
      logic [MONTH_W-1:0] result_month;
      logic [YEAR_W-1:0]  result_year;
      logic               invalid;
   } gdad_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture a new item
      logic check;   // validate start date, seed reach
      logic step;    // advance one month
      logic finish;  // capture the valid result
   } gdad_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic bad;     // start date out of range
      logic reached; // offset lands in the current month
   } gdad_sts_type;

   // Leap year: divisible by 400, or by 4 and not by 100.
   // 400 = 16*25 and 100 = 4*25, so only a divide-by-25 test is needed.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [PROD_W-1:0] prod;
      logic [QUOT_W-1:0] quot;
      logic [QUOT_W+4:0] back;
      logic              div25;
      prod  = PROD_W'(year) * PROD_W'(RECIP_25);
      quot  = prod[PROD_W-1:RECIP_SHIFT];
      back  = ({quot, 4'b0000} + {1'b0, quot, 3'b000}) + (QUOT_W+5)'(quot);
      div25 = (back == (QUOT_W+5)'(year));
      return ((year[3:0] == 4'd0) && div25) || ((year[1:0] == 2'd0) && !div25);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic               leap);
      logic [DAY_W-1:0] len;
      if (month == MONTH_FEB) begin
         len = leap ? LEN_29 : LEN_28;
      end else if (month <= MONTH_JUL) begin
         len = month[0] ? LEN_31 : LEN_30;
      end else begin
         len = month[0] ? LEN_30 : LEN_31;
      end
      return len;
   endfunction

endpackage

FILE: rtl/core/gdad_ctrl.sv
// Controller for the date advance unit: sequences load, check, month walk
// and result strobe. Depends on gdad_pkg.
module gdad_ctrl
   import gdad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  gdad_sts_type sts,
   output gdad_cmd_type cmd,
   output logic         busy,
   output logic         strobe
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      strobe_in  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.bad) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.reached) begin
               cmd.finish = 1'b1;
               strobe_in  = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign strobe = strobe_ff;

endmodule

FILE: rtl/core/gdad_dp.sv
// Datapath for the date advance unit: date and reach registers, month
// length logic and the result register. Depends on gdad_pkg.
module gdad_dp
   import gdad_pkg::*;
(
   input  logic         clock,
   input  gdad_req_type req_item,
   input  gdad_cmd_type cmd,
   output gdad_sts_type sts,
   output gdad_rsp_type rsp_item
);

   logic [DAY_W-1:0]    day_ff,    day_in;
   logic [MONTH_W-1:0]  month_ff,  month_in;
   logic [YEAR_W-1:0]   year_ff,   year_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [REACH_W-1:0]  reach_ff,  reach_in;
   gdad_rsp_type        rsp_ff,    rsp_in;

   logic                leap_cur;
   logic [DAY_W-1:0]    len_cur;
   logic [MONTH_W-1:0]  month_next;
   logic [DAY_W-1:0]    len_next;
   logic [REACH_W-1:0]  gap;
   logic                month_ok;

   // Month lengths; a step into January keeps 31 whatever the year
   always_comb begin
      leap_cur   = is_leap(year_ff);
      len_cur    = month_len(month_ff, leap_cur);
      month_next = (month_ff == MONTH_DEC) ? MONTH_JAN : month_ff + MONTH_JAN;
      len_next   = month_len(month_next, leap_cur);
      gap        = reach_ff - REACH_W'(offset_ff);
      month_ok   = month_ff inside {[MONTH_JAN:MONTH_DEC]};
   end

   // Status to controller
   always_comb begin
      sts.bad     = !month_ok || (day_ff == '0) || (day_ff > len_cur);
      sts.reached = (REACH_W'(offset_ff) <= reach_ff);
   end

   // Date registers
   always_comb begin
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      offset_in = offset_ff;
      reach_in  = reach_ff;
      if (cmd.load) begin
         day_in    = req_item.start_day;
         month_in  = req_item.start_month;
         year_in   = req_item.start_year;
         offset_in = req_item.day_offset;
      end else if (cmd.check) begin
         reach_in  = REACH_W'(len_cur - day_ff);
      end else if (cmd.step) begin
         month_in  = month_next;
         if (month_ff == MONTH_DEC) begin
            year_in = year_ff + YEAR_W'(1);
         end
         reach_in  = reach_ff + REACH_W'(len_next);
      end
   end

   // Result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.check && sts.bad) begin
         rsp_in         = '0;
         rsp_in.invalid = 1'b1;
      end else if (cmd.finish) begin
         rsp_in.result_day   = len_cur - gap[DAY_W-1:0];
         rsp_in.result_month = month_ff;
         rsp_in.result_year  = year_ff;
         rsp_in.invalid      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      day_ff    <= day_in;
      month_ff  <= month_in;
      year_ff   <= year_in;
      offset_ff <= offset_in;
      reach_ff  <= reach_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

FILE: rtl/core/gregorian_date_add_days_unit.sv
// Top level of the Gregorian date advance unit: joins controller and
// datapath. Depends on gdad_pkg, gdad_ctrl, gdad_dp.
//
//   channel   | ports                      | handshake
//   ----------+----------------------------+-------------------------------
//   request   | start, busy, req_item      | taken when start && !busy
//   response  | rsp_strobe, rsp_item       | one-cycle strobe, no back-pressure
//
// After acceptance an item goes to the check state, then to the walk,
// which steps once per month boundary crossed (up to about 2150 for the
// largest offset); the walk adds one month per cycle. A bad start date
// strobes from the check state. busy is high from acceptance until the
// strobe cycle. Reset is synchronous and returns the controller to idle.
// The receiver cannot stall; each result shows for exactly one cycle.
module gregorian_date_add_days_unit
   import gdad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  gdad_req_type req_item,
   output logic         rsp_strobe,
   output gdad_rsp_type rsp_item
);

   gdad_cmd_type cmd;
   gdad_sts_type sts;

   gdad_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   gdad_dp u_dp (
      .clock    (clock),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule
